### sv/mie_pkg.sv
// shared types and constants for the modular inverse block
`default_nettype none

package mie_pkg;

    localparam int unsigned WORD_BITS_DEF = 31;
    localparam logic [62:0] MODULUS_RESET = 63'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### sv/mie_ctrl.sv
// sequencer for the euclid rounds and the shared divider
`default_nettype none

module mie_ctrl
    import mie_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  wire     aclk,
    input  wire     aresetn,
    input  wire     s_tvalid,
    output logic    s_tready,
    output cmd_t    cmd,
    input  status_t status
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.cur_zero) begin
                    state_next = ST_FINAL;
                end else begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/mie_dp.sv
// euclid datapath: remainders, coefficients, radix-2 divider and result register
`default_nettype none

module mie_dp
    import mie_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [WORD_BITS-1:0]  value,
    input  wire [WORD_BITS-1:0]  modulus,
    input  cmd_t                 cmd,
    output status_t              status,
    input  wire                  m_tready,
    output logic                 m_tvalid,
    output logic [WORD_BITS-1:0] inverse,
    output logic [WORD_BITS-1:0] common_divisor
);

    // coefficients stay within about twice the modulus in magnitude
    localparam int unsigned S_W = WORD_BITS + 2;

    logic [WORD_BITS-1:0]  m_reg;
    logic [WORD_BITS-1:0]  prev_r_reg, cur_r_reg;
    logic [WORD_BITS-1:0]  rem_reg, dvd_reg;
    logic signed [S_W-1:0] prev_s_reg, cur_s_reg, t_reg;
    logic [WORD_BITS-1:0]  inv_reg, gcd_reg;
    logic                  valid_reg;

    logic [WORD_BITS:0]    rem_shift, rem_diff;
    logic                  qbit;
    logic [WORD_BITS-1:0]  rem_step;
    logic signed [S_W-1:0] t_step;
    logic signed [S_W-1:0] m_ext, s_add, s_sub;
    logic [WORD_BITS-1:0]  inv_val;

    // one quotient bit per step, msb first; t accumulates q * cur_s by horner
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[WORD_BITS-1]};
        rem_diff  = rem_shift - {1'b0, cur_r_reg};
        qbit      = ~rem_diff[WORD_BITS];
        rem_step  = qbit ? rem_diff[WORD_BITS-1:0] : rem_shift[WORD_BITS-1:0];
        t_step    = (t_reg <<< 1) + (qbit ? cur_s_reg : {S_W{1'b0}});
    end

    // bring the final coefficient into [0, m)
    always_comb begin
        m_ext = $signed({2'b00, m_reg});
        s_add = prev_s_reg + m_ext;
        s_sub = prev_s_reg - m_ext;
        if (m_reg == '0) begin
            inv_val = '0;
        end else if (prev_s_reg < 0) begin
            inv_val = s_add[WORD_BITS-1:0];
        end else if (prev_s_reg >= m_ext) begin
            inv_val = s_sub[WORD_BITS-1:0];
        end else begin
            inv_val = prev_s_reg[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg      <= modulus;
            prev_r_reg <= value;
            cur_r_reg  <= modulus;
            prev_s_reg <= S_W'(1);
            cur_s_reg  <= '0;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= prev_r_reg;
            t_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
            t_reg   <= t_step;
        end
        if (cmd.update) begin
            prev_r_reg <= cur_r_reg;
            cur_r_reg  <= rem_reg;
            prev_s_reg <= cur_s_reg;
            cur_s_reg  <= prev_s_reg - t_reg;
        end
        if (cmd.out_load) begin
            inv_reg <= inv_val;
            gcd_reg <= prev_r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign status.cur_zero = (cur_r_reg == '0);
    assign status.out_free = ~valid_reg | m_tready;
    assign m_tvalid        = valid_reg;
    assign inverse         = inv_reg;
    assign common_divisor  = gcd_reg;

endmodule

`default_nettype wire

### sv/modular_inverse_ext_euclid.sv
// top level of the modular inverse block (extended euclid)
// Computes the inverse of value modulo the configured modulus with the
// extended euclidean algorithm and returns it with gcd(value, modulus); the
// inverse is meaningful only when that gcd is 1, a value of zero gives an
// inverse of 0 and a gcd equal to the modulus, a modulus of zero gives an
// inverse of 0 and a gcd equal to the value. One item is worked on at a time.
// Each euclid round is one check, WORD_BITS steps of the shared radix-2
// divider and one update; an item takes as many rounds as euclid needs
// (up to about 45 at 31 bits) from transfer in to result ready. A finished
// result sits in an output register, so the next item is taken while it
// waits for its transfer. The user must write the modulus over the cfg
// channel only while the block is idle; the block does not enforce this.
// Reset loads 1e9+7.
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF,
    localparam int unsigned IN_W  = ((WORD_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // input item
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [IN_W-1:0]       s_tdata,   // value, zero pad
    // result item
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // inverse, common_divisor, zero pad
    // modulus register write
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [WORD_BITS-1:0]  cfg_data   // modulus
);

    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] inverse, common_divisor;
    cmd_t                 cmd;
    status_t              status;

    // modulus register, always ready for a transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET[WORD_BITS-1:0];
        end else if (cfg_valid) begin
            modulus_reg <= cfg_data;
        end
    end

    // state machine: load, check for zero remainder, divide, update, finish
    mie_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // remainder and coefficient registers, divider, output register
    mie_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .value          (s_tdata[WORD_BITS-1:0]),
        .modulus        (modulus_reg),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .inverse        (inverse),
        .common_divisor (common_divisor)
    );

    // inverse in the low bits, gcd above it, zeros up to the byte boundary
    assign m_tdata = OUT_W'({common_divisor, inverse});

endmodule

`default_nettype wire

### sv/mie_chk.sv
// port checker for the modular inverse block, bound to the top level
`default_nettype none

module mie_chk
    import mie_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [((2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    // a result register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: no second transfer right after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a result only appears at the end of the work on an item
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind modular_inverse_ext_euclid mie_chk #(
    .WORD_BITS (WORD_BITS)
) u_mie_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### verif/modular_inverse_ext_euclid_test.sv
// testbench for the modular inverse block: streamed values checked against a euclid predictor
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_test;

    import mie_pkg::*;

    localparam int unsigned W = WORD_BITS_DEF;
    localparam int unsigned IN_BYTES_W = ((W + 7) / 8) * 8;
    localparam int unsigned OUT_BYTES_W = ((2 * W + 7) / 8) * 8;
    // worst item: ~46 euclid rounds, taken many times over
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;
    localparam bit [W-1:0] FIB_46 = 31'd1836311903;
    localparam bit [W-1:0] FIB_45 = 31'd1134903170;
    localparam bit [W-1:0] FIB_44 = 31'd701408733;
    localparam bit [W-1:0] WORD_MAX = {W{1'b1}};

    // which side of the stream inserts bubbles during a phase
    typedef enum int {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } gap_mode_t;

    typedef struct {
        bit [W-1:0] inverse;
        bit [W-1:0] common_divisor;
    } inverse_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES_W-1:0]  s_tdata;    // value, zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;    // inverse, common_divisor, zero pad
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [W-1:0]           cfg_data;   // modulus

    bit [W-1:0]      pending_values[$];
    inverse_result_t expected_results[$];
    bit [W-1:0]      modulus_setting;
    gap_mode_t       gap_mode;
    int unsigned     fail_count;
    longint unsigned cycle_count;

    modular_inverse_ext_euclid i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // append a value to the stimulus queue
    function automatic void add_value(input bit [W-1:0] v);
        pending_values.insert(pending_values.size(), v);
    endfunction

    // append a prediction to the scoreboard queue
    function automatic void add_expected(input inverse_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // iterative extended euclid, keeping only the coefficient of the value
    function automatic inverse_result_t predict_inverse(bit [W-1:0] a, bit [W-1:0] m);
        longint unsigned prev_r;
        longint unsigned cur_r;
        longint unsigned next_r;
        longint unsigned quot;
        longint          prev_s;
        longint          cur_s;
        longint          next_s;
        longint          m_signed;
        longint          rem;
        inverse_result_t res;
        prev_r = a;
        cur_r = m;
        prev_s = 1;
        cur_s = 0;
        while (cur_r != 0) begin
            quot = prev_r / cur_r;
            next_r = prev_r - quot * cur_r;
            next_s = prev_s - $signed(quot) * cur_s;
            prev_r = cur_r;
            cur_r = next_r;
            prev_s = cur_s;
            cur_s = next_s;
        end
        res.inverse = '0;
        // no reduction possible with a zero modulus
        if (m != 0) begin
            m_signed = m;
            rem = prev_s % m_signed;
            if (rem < 0) begin
                rem = rem + m_signed;
            end
            res.inverse = rem[W-1:0];
        end
        res.common_divisor = prev_r[W-1:0];
        return res;
    endfunction

    // bubble decision for one side in the current phase
    function automatic bit take_gap(bit receiver_side);
        int unsigned roll;
        roll = $urandom_range(99, 0);
        case (gap_mode)
            GAP_SENDER:   return !receiver_side && roll < 85;
            GAP_RECEIVER: return receiver_side && roll < 85;
            GAP_BOTH:     return roll < 24;
            default:      return 1'b0;
        endcase
    endfunction

    // mostly reduced values, with full-width, tiny and near-modulus ones mixed in
    function automatic bit [W-1:0] pick_value(bit [W-1:0] m);
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 60) begin
            return (m > 1) ? W'($urandom_range(m - 1, 0)) : W'($urandom_range(3, 0));
        end else if (roll < 75) begin
            return W'($urandom);
        end else if (roll < 85) begin
            return W'($urandom_range(16, 0));
        end else if (roll < 93) begin
            return m - W'($urandom_range(1, 0));
        end else begin
            return m + W'($urandom_range(2, 1));
        end
    endfunction

    // driver: prediction is taken at the transfer, the modulus only moves while idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                add_expected(predict_inverse(s_tdata[W-1:0], modulus_setting));
            end
            // hold a presented item until it is taken
            if (!s_tvalid || s_tready) begin
                if (pending_values.size() != 0 && !take_gap(1'b0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_BYTES_W - W){1'b0}}, pending_values.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: every result transfer is matched against the oldest prediction
    always @(posedge aclk) begin
        inverse_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result inverse %0d gcd %0d", $time,
                             m_tdata[W-1:0], m_tdata[2*W-1:W]);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[W-1:0] !== want.inverse) begin
                        $display("%0t: inverse expected %0d actual %0d", $time,
                                 want.inverse, m_tdata[W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[2*W-1:W] !== want.common_divisor) begin
                        $display("%0t: common_divisor expected %0d actual %0d", $time,
                                 want.common_divisor, m_tdata[2*W-1:W]);
                        fail_count++;
                    end
                end
            end
            m_tready <= !take_gap(1'b1);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // wait until every queued value has gone in and every result has come back
    task automatic drain();
        while (pending_values.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // modulus register write, only called with the block drained
    task automatic write_modulus(input bit [W-1:0] m);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        modulus_setting = m;
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count) begin
            add_value(pick_value(modulus_setting));
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        aresetn = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        gap_mode = GAP_NONE;
        modulus_setting = MODULUS_RESET[W-1:0];

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset modulus 1e9+7: zero, unit, edges, values at and above the modulus,
        // a multiple of the modulus (no inverse) and the full-width value
        add_value('0);
        add_value(31'd1);
        add_value(31'd2);
        add_value(31'd500000004);
        add_value(modulus_setting - W'(1));
        add_value(modulus_setting);
        add_value(modulus_setting + W'(1));
        add_value(modulus_setting * W'(2));
        add_value(WORD_MAX);
        add_value(31'h2AAAAAAA);
        add_value(31'h55555555);
        queue_random(150);
        drain();

        // largest modulus, every value bit toggles here
        write_modulus(WORD_MAX);
        gap_mode = GAP_SENDER;
        add_value(WORD_MAX);
        add_value(WORD_MAX - W'(1));
        queue_random(250);
        drain();

        // smallest ordinary modulus
        write_modulus(31'd2);
        gap_mode = GAP_RECEIVER;
        queue_random(100);
        drain();

        // consecutive fibonacci numbers force the longest euclid chain
        write_modulus(FIB_46);
        gap_mode = GAP_BOTH;
        add_value(FIB_45);
        add_value(FIB_44);
        add_value(FIB_46 - W'(1));
        queue_random(150);
        drain();

        // composite modulus, many values share a factor with it
        write_modulus(31'd1000);
        gap_mode = GAP_NONE;
        add_value(31'd500);
        add_value(31'd7);
        queue_random(200);
        drain();

        // degenerate moduli of one and zero
        write_modulus(31'd1);
        gap_mode = GAP_SENDER;
        queue_random(40);
        drain();

        write_modulus('0);
        gap_mode = GAP_RECEIVER;
        add_value('0);
        add_value(WORD_MAX);
        queue_random(40);
        drain();

        write_modulus(W'($urandom_range(32'h7FFFFFFF, 3)));
        gap_mode = GAP_BOTH;
        queue_random(250);
        drain();

        write_modulus(31'd65537);
        gap_mode = GAP_RECEIVER;
        queue_random(200);
        drain();

        write_modulus(WORD_MAX);
        gap_mode = GAP_BOTH;
        queue_random(260);
        drain();

        // let any stray result show up before judging
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/mie_pkg.sv
sv/mie_ctrl.sv
sv/mie_dp.sv
sv/modular_inverse_ext_euclid.sv
sv/mie_chk.sv
verif/modular_inverse_ext_euclid_test.sv
